// ===== sv/tsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Topological sort package
// Shared widths, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tsk_pkg;

    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CYCLE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_WR,
        ST_INS_LINK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP_RD,
        ST_POP_HEAD,
        ST_HEAD_W,
        ST_EDGE_RD,
        ST_EDGE_DEG,
        ST_EDGE_UPD,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT,
        ST_RES_WAIT
    } t_state;

endpackage

// ===== sv/tsk_if.sv =====
// ----------------------------------------------------------------------------
// Topological sort channels
// Valid/ready channels for edge items and for result items.
// ----------------------------------------------------------------------------
interface tsk_in_if;
    logic                          valid;
    logic                          ready;
    logic [tsk_pkg::VERTEX_W-1:0]  from_vertex;
    logic [tsk_pkg::VERTEX_W-1:0]  to_vertex;
    logic                          carries_edge;
    logic                          end_of_graph;

    modport source (output valid, output from_vertex, output to_vertex,
                    output carries_edge, output end_of_graph, input ready);
    modport sink   (input valid, input from_vertex, input to_vertex,
                    input carries_edge, input end_of_graph, output ready);
endinterface

interface tsk_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsk_pkg::VERTEX_W-1:0]  order_vertex;
    logic [tsk_pkg::STATUS_W-1:0]  status;
    logic                          last_result;

    modport source (output valid, output order_vertex, output status,
                    output last_result, input ready);
    modport sink   (input valid, input order_vertex, input status,
                    input last_result, output ready);
endinterface

// ===== sv/topological_sort_kahn.sv =====
// ----------------------------------------------------------------------------
// Kahn topological sort
// Collects directed edges and emits a topological order, a cycle result or
// an error result once the end of the graph is seen.
// ----------------------------------------------------------------------------
// Usage: edges arrive on i_in, one per transaction. Each edge is appended to
// its source's out-list and counts toward its destination's in-degree in
// ST_INS_WR, followed by ST_INS_LINK when the source already has edges. The
// transaction marked end_of_graph starts the sort. The sort scans every
// vertex slot, then pops each ready vertex and walks its out-edges, all
// through the same small set of single-port-read memories that hold the
// graph. Results follow on o_out, each held through any receiver stall:
// either the full order, one cycle result or one error result, the last
// one flagged by last_result. The block then clears all MAX_VERTICES slots
// of its head and in-degree tables before it takes the next edge. After
// reset the same clearing pass runs first. i_in.ready is low for the whole
// sort and while a result waits; a stalled receiver simply holds the block.
// vertex_count must be written through i_cfg_we/i_cfg_wdata only while the
// block is idle; the block itself leaves this to the user.
// ----------------------------------------------------------------------------
module topological_sort_kahn #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tsk_pkg::CFG_W-1:0]   i_cfg_wdata,
    tsk_in_if.sink                      i_in,
    tsk_out_if.source                   o_out
);

    localparam int VA = $clog2(MAX_VERTICES);
    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int EA = $clog2(MAX_EDGES);
    localparam int EP = $clog2(MAX_EDGES + 1);
    localparam logic [EP-1:0] NIL     = EP'(MAX_EDGES);
    localparam logic [VC-1:0] LAST_VX = VC'(MAX_VERTICES - 1);

    tsk_pkg::t_state r_state, n_state;

    logic [tsk_pkg::CFG_W-1:0] r_vcount;
    logic [VC-1:0]             w_n;
    logic [VA-1:0]             r_u, r_v;
    logic [EP-1:0]             r_e, r_tail, r_edge_total;
    logic                      r_err, r_end;
    logic [VC-1:0]             r_idx, r_rd_pos, r_wr_pos;
    logic                      r_out_valid, r_out_last;
    logic [tsk_pkg::VERTEX_W-1:0] r_out_vertex;
    logic [tsk_pkg::STATUS_W-1:0] r_out_status;

    // Memory ports.
    logic          head_we;  logic [VA-1:0] head_wa, head_ra;  logic [EP-1:0] head_wd, head_rd;
    logic          tail_we;  logic [VA-1:0] tail_wa, tail_ra;  logic [EP-1:0] tail_wd, tail_rd;
    logic          deg_we;   logic [VA-1:0] deg_wa, deg_ra;    logic [EP-1:0] deg_wd, deg_rd;
    logic          tgt_we;   logic [EA-1:0] tgt_wa, tgt_ra;    logic [VA-1:0] tgt_wd, tgt_rd;
    logic          link_we;  logic [EA-1:0] link_wa, link_ra;  logic [EP-1:0] link_wd, link_rd;
    logic          q_we;     logic [VA-1:0] q_wa, q_ra;        logic [VA-1:0] q_wd, q_rd;

    logic in_acc, in_bad, scan_bad, scan_push, upd_hit, upd_push, out_acc;

    tsk_ram #(.WIDTH(EP), .DEPTH(MAX_VERTICES)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_rd));
    tsk_ram #(.WIDTH(EP), .DEPTH(MAX_VERTICES)) u_tail (
        .i_clk(i_clk), .i_we(tail_we), .i_waddr(tail_wa), .i_wdata(tail_wd),
        .i_raddr(tail_ra), .o_rdata(tail_rd));
    tsk_ram #(.WIDTH(EP), .DEPTH(MAX_VERTICES)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_wa), .i_wdata(deg_wd),
        .i_raddr(deg_ra), .o_rdata(deg_rd));
    tsk_ram #(.WIDTH(VA), .DEPTH(MAX_EDGES)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa), .i_wdata(tgt_wd),
        .i_raddr(tgt_ra), .o_rdata(tgt_rd));
    tsk_ram #(.WIDTH(EP), .DEPTH(MAX_EDGES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(link_ra), .o_rdata(link_rd));
    tsk_ram #(.WIDTH(VA), .DEPTH(MAX_VERTICES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(q_rd));

    // Effective vertex count: zero acts as one, large values saturate.
    always_comb begin
        if (r_vcount == '0) begin
            w_n = VC'(1);
        end else if (r_vcount > tsk_pkg::CFG_W'(MAX_VERTICES)) begin
            w_n = VC'(MAX_VERTICES);
        end else begin
            w_n = VC'(r_vcount);
        end
    end

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = r_out_valid && o_out.ready;
    assign in_bad  = ({1'b0, i_in.from_vertex} >= 7'(MAX_VERTICES))
                  || ({1'b0, i_in.to_vertex} >= 7'(MAX_VERTICES))
                  || (r_edge_total >= NIL);

    // Slots at or above n must be untouched; slots below n with no inputs start
    // the ready queue in index order.
    assign scan_push = (r_idx < w_n) && (deg_rd == '0);
    assign scan_bad  = (r_idx >= w_n) && ((head_rd != NIL) || (deg_rd != '0));
    assign upd_hit   = (VC'(r_v) < w_n) && (deg_rd != '0);
    assign upd_push  = upd_hit && (deg_rd == EP'(1)) && (r_wr_pos < w_n);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsk_pkg::ST_CLEAR: begin
                if (r_idx == LAST_VX) n_state = tsk_pkg::ST_IDLE;
            end
            tsk_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.carries_edge && !in_bad) n_state = tsk_pkg::ST_INS_WR;
                    else if (i_in.end_of_graph)       n_state = tsk_pkg::ST_SCAN_RD;
                end
            end
            tsk_pkg::ST_INS_WR: begin
                if (head_rd != NIL) n_state = tsk_pkg::ST_INS_LINK;
                else if (r_end)     n_state = tsk_pkg::ST_SCAN_RD;
                else                n_state = tsk_pkg::ST_IDLE;
            end
            tsk_pkg::ST_INS_LINK: begin
                n_state = r_end ? tsk_pkg::ST_SCAN_RD : tsk_pkg::ST_IDLE;
            end
            tsk_pkg::ST_SCAN_RD:  n_state = tsk_pkg::ST_SCAN_CHK;
            tsk_pkg::ST_SCAN_CHK: begin
                if (r_idx != LAST_VX)     n_state = tsk_pkg::ST_SCAN_RD;
                else if (r_err || scan_bad) n_state = tsk_pkg::ST_RES_WAIT;
                else                      n_state = tsk_pkg::ST_POP_RD;
            end
            tsk_pkg::ST_POP_RD: begin
                if (r_rd_pos < r_wr_pos)   n_state = tsk_pkg::ST_POP_HEAD;
                else if (r_wr_pos != w_n)  n_state = tsk_pkg::ST_RES_WAIT;
                else                       n_state = tsk_pkg::ST_OUT_RD;
            end
            tsk_pkg::ST_POP_HEAD: n_state = tsk_pkg::ST_HEAD_W;
            tsk_pkg::ST_HEAD_W:   n_state = tsk_pkg::ST_EDGE_RD;
            tsk_pkg::ST_EDGE_RD: begin
                n_state = (r_e < NIL) ? tsk_pkg::ST_EDGE_DEG : tsk_pkg::ST_POP_RD;
            end
            tsk_pkg::ST_EDGE_DEG: n_state = tsk_pkg::ST_EDGE_UPD;
            tsk_pkg::ST_EDGE_UPD: n_state = tsk_pkg::ST_EDGE_RD;
            tsk_pkg::ST_OUT_RD:   n_state = tsk_pkg::ST_OUT_LD;
            tsk_pkg::ST_OUT_LD:   n_state = tsk_pkg::ST_OUT_WAIT;
            tsk_pkg::ST_OUT_WAIT: begin
                if (out_acc) n_state = r_out_last ? tsk_pkg::ST_CLEAR : tsk_pkg::ST_OUT_RD;
            end
            tsk_pkg::ST_RES_WAIT: begin
                if (out_acc) n_state = tsk_pkg::ST_CLEAR;
            end
            default: n_state = tsk_pkg::ST_CLEAR;
        endcase
    end

    // Memory control.
    always_comb begin
        head_we = 1'b0; head_wa = r_u;  head_wd = r_e;  head_ra = r_idx[VA-1:0];
        tail_we = 1'b0; tail_wa = r_u;  tail_wd = r_edge_total; tail_ra = i_in.from_vertex[VA-1:0];
        deg_we  = 1'b0; deg_wa  = r_v;  deg_wd  = deg_rd + EP'(1); deg_ra = r_idx[VA-1:0];
        tgt_we  = 1'b0; tgt_wa  = r_edge_total[EA-1:0]; tgt_wd = r_v; tgt_ra = r_e[EA-1:0];
        link_we = 1'b0; link_wa = r_edge_total[EA-1:0]; link_wd = NIL; link_ra = r_e[EA-1:0];
        q_we    = 1'b0; q_wa    = r_wr_pos[VA-1:0]; q_wd = r_v; q_ra = r_rd_pos[VA-1:0];
        case (r_state)
            tsk_pkg::ST_CLEAR: begin
                head_we = 1'b1; head_wa = r_idx[VA-1:0]; head_wd = NIL;
                deg_we  = 1'b1; deg_wa  = r_idx[VA-1:0]; deg_wd  = '0;
            end
            tsk_pkg::ST_IDLE: begin
                head_ra = i_in.from_vertex[VA-1:0];
                deg_ra  = i_in.to_vertex[VA-1:0];
            end
            tsk_pkg::ST_INS_WR: begin
                tgt_we  = 1'b1;
                link_we = 1'b1;
                tail_we = 1'b1;
                deg_we  = 1'b1;
                head_we = (head_rd == NIL);
                head_wd = r_edge_total;
            end
            tsk_pkg::ST_INS_LINK: begin
                link_we = 1'b1; link_wa = r_tail[EA-1:0]; link_wd = r_e;
            end
            tsk_pkg::ST_SCAN_CHK: begin
                q_we = scan_push; q_wd = r_idx[VA-1:0];
            end
            tsk_pkg::ST_POP_HEAD: head_ra = q_rd;
            tsk_pkg::ST_EDGE_DEG: deg_ra  = tgt_rd;
            tsk_pkg::ST_EDGE_UPD: begin
                deg_we = upd_hit; deg_wd = deg_rd - EP'(1);
                q_we   = upd_push;
            end
            tsk_pkg::ST_OUT_RD: q_ra = r_idx[VA-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tsk_pkg::ST_CLEAR;
            r_vcount     <= tsk_pkg::VCOUNT_RESET;
            r_idx        <= '0;
            r_rd_pos     <= '0;
            r_wr_pos     <= '0;
            r_edge_total <= '0;
            r_err        <= 1'b0;
            r_end        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            case (r_state)
                tsk_pkg::ST_CLEAR: begin
                    r_idx        <= (r_idx == LAST_VX) ? '0 : r_idx + VC'(1);
                    r_rd_pos     <= '0;
                    r_wr_pos     <= '0;
                    r_edge_total <= '0;
                    r_err        <= 1'b0;
                end
                tsk_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_u   <= i_in.from_vertex[VA-1:0];
                        r_v   <= i_in.to_vertex[VA-1:0];
                        r_end <= i_in.end_of_graph;
                        r_idx <= '0;
                        if (i_in.carries_edge && in_bad) r_err <= 1'b1;
                    end
                end
                tsk_pkg::ST_INS_WR: begin
                    r_tail       <= tail_rd;
                    r_e          <= r_edge_total;
                    r_edge_total <= r_edge_total + EP'(1);
                end
                tsk_pkg::ST_SCAN_CHK: begin
                    if (scan_push) r_wr_pos <= r_wr_pos + VC'(1);
                    if (scan_bad)  r_err <= 1'b1;
                    r_idx <= r_idx + VC'(1);
                    if (r_idx == LAST_VX && (r_err || scan_bad)) begin
                        r_out_valid  <= 1'b1;
                        r_out_vertex <= '0;
                        r_out_status <= tsk_pkg::STATUS_ERROR;
                        r_out_last   <= 1'b1;
                    end
                end
                tsk_pkg::ST_POP_RD: begin
                    r_idx <= '0;
                    if (r_rd_pos < r_wr_pos) begin
                        r_rd_pos <= r_rd_pos + VC'(1);
                    end else if (r_wr_pos != w_n) begin
                        r_out_valid  <= 1'b1;
                        r_out_vertex <= '0;
                        r_out_status <= tsk_pkg::STATUS_CYCLE;
                        r_out_last   <= 1'b1;
                    end
                end
                tsk_pkg::ST_HEAD_W:   r_e <= head_rd;
                tsk_pkg::ST_EDGE_DEG: begin
                    r_v <= tgt_rd;
                    r_e <= link_rd;
                end
                tsk_pkg::ST_EDGE_UPD: begin
                    if (upd_push) r_wr_pos <= r_wr_pos + VC'(1);
                end
                tsk_pkg::ST_OUT_LD: begin
                    r_out_valid  <= 1'b1;
                    r_out_vertex <= tsk_pkg::VERTEX_W'(q_rd);
                    r_out_status <= tsk_pkg::STATUS_ORDER;
                    r_out_last   <= (r_idx == w_n - VC'(1));
                end
                tsk_pkg::ST_OUT_WAIT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_idx       <= r_out_last ? '0 : r_idx + VC'(1);
                    end
                end
                tsk_pkg::ST_RES_WAIT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_idx       <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready         = (r_state == tsk_pkg::ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.order_vertex = r_out_vertex;
    assign o_out.status       = r_out_status;
    assign o_out.last_result  = r_out_last;

endmodule

// ===== sv/tsk_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tsk_checker.sv =====
// ----------------------------------------------------------------------------
// Topological sort port checker
// Watches the channels of the sorter for ordering and result rules.
// ----------------------------------------------------------------------------
module tsk_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tsk_pkg::VERTEX_W-1:0]  i_out_vertex,
    input logic [tsk_pkg::STATUS_W-1:0]  i_out_status,
    input logic                          i_out_last
);

    // No new edge is taken while a result is pending.
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_vertex)
        && $stable(i_out_status) && $stable(i_out_last))
        else $error("stalled result changed");

    // Cycle and error results stand alone.
    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != tsk_pkg::STATUS_ORDER)
        |-> i_out_last && (i_out_vertex == '0))
        else $error("failure result is not a lone final result");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid && !i_in_ready)
        else $error("activity right after the final result");

endmodule

bind topological_sort_kahn tsk_checker u_tsk_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_vertex (o_out.order_vertex),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last_result)
);

// ===== bench/topological_sort_kahn_tb.sv =====
// ----------------------------------------------------------------------------
// Kahn topological sort testbench
// Streams graphs of directed edges into the block, predicts the topological
// order, cycle or error result of each graph and checks every result.
// ----------------------------------------------------------------------------
module topological_sort_kahn_tb;

    localparam int NV = 64;
    localparam int NE = 512;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [tsk_pkg::VERTEX_W-1:0] vtx;
        logic [tsk_pkg::STATUS_W-1:0] st;
        logic                         last;
    } t_result;

    // Shadow graph and result checker.
    class t_sort_scoreboard;
        int unsigned vcount;
        int unsigned tgt[NE];
        int unsigned nxt[NE];
        int unsigned head[NV];
        int unsigned tail[NV];
        int unsigned indeg[NV];
        int unsigned n_edges;
        bit          bad;
        t_result     pending[$];
        int          errors;
        int          checked;

        function void expect_result(t_result r);
            pending = {pending, r};
        endfunction

        function void clear_graph();
            for (int i = 0; i < NV; i++) begin
                head[i] = NE;
                tail[i] = NE;
                indeg[i] = 0;
            end
            n_edges = 0;
            bad = 0;
        endfunction

        function void add_edge(int unsigned u, int unsigned v);
            if (n_edges >= NE) begin
                bad = 1;
                return;
            end
            tgt[n_edges] = v;
            nxt[n_edges] = NE;
            if (head[u] == NE) head[u] = n_edges;
            else nxt[tail[u]] = n_edges;
            tail[u] = n_edges;
            indeg[v]++;
            n_edges++;
        endfunction

        function void sort_graph();
            int unsigned n, rd, wr, u, e, v, k;
            int unsigned q[NV];
            t_result r;
            n = vcount;
            if (n == 0) n = 1;
            if (n > NV) n = NV;
            for (int i = n; i < NV; i++)
                if (head[i] != NE || indeg[i] != 0) bad = 1;
            if (bad) begin
                r = '{vtx: '0, st: tsk_pkg::STATUS_ERROR, last: 1'b1};
                expect_result(r);
                return;
            end
            rd = 0;
            wr = 0;
            for (int i = 0; i < n; i++)
                if (indeg[i] == 0) q[wr++] = i;
            while (rd < wr) begin
                u = q[rd++];
                e = head[u];
                k = 0;
                while (e < NE && k < NE) begin
                    v = tgt[e];
                    if (v < n && indeg[v] != 0) begin
                        indeg[v]--;
                        if (indeg[v] == 0 && wr < n) q[wr++] = v;
                    end
                    e = nxt[e];
                    k++;
                end
            end
            if (wr != n) begin
                r = '{vtx: '0, st: tsk_pkg::STATUS_CYCLE, last: 1'b1};
                expect_result(r);
                return;
            end
            for (int i = 0; i < n; i++) begin
                r = '{vtx: q[i][tsk_pkg::VERTEX_W-1:0], st: tsk_pkg::STATUS_ORDER,
                      last: (i == n - 1)};
                expect_result(r);
            end
        endfunction

        function void note_item(logic [5:0] u, logic [5:0] v, logic ce, logic eog);
            if (ce) add_edge(32'(u), 32'(v));
            if (eog) begin
                sort_graph();
                clear_graph();
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result vtx=%0d st=%0d last=%0d",
                         $time, got.vtx, got.st, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display({"%0t: result mismatch expected vtx=%0d st=%0d last=%0d,",
                          " actual vtx=%0d st=%0d last=%0d"},
                         $time, want.vtx, want.st, want.last,
                         got.vtx, got.st, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tsk_pkg::CFG_W-1:0] i_cfg_wdata = '0;

    tsk_in_if  in_ch();
    tsk_out_if out_ch();

    topological_sort_kahn i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    t_sort_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;
    int graphs = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.from_vertex = '0;
        in_ch.to_vertex = '0;
        in_ch.carries_edge = 1'b0;
        in_ch.end_of_graph = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Receiver: ready toggles at the falling edge, results sampled at the rising edge.
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{vtx: out_ch.order_vertex, st: out_ch.status,
                              last: out_ch.last_result});
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("topological_sort_kahn_tb NOT OK");
            $finish;
        end
    end

    // Valid stays high into the next item when there is no idle gap, so the
    // caller either sends again or drains at the falling edge where this returns.
    task automatic send_item(input logic [5:0] u, input logic [5:0] v,
                             input logic ce, input logic eog);
        if ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle);
        end
        in_ch.valid <= 1'b1;
        in_ch.from_vertex <= u;
        in_ch.to_vertex <= v;
        in_ch.carries_edge <= ce;
        in_ch.end_of_graph <= eog;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(u, v, ce, eog);
        if (eog) graphs++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (2 * NV + 20) @(negedge i_clk);
    endtask

    task automatic set_vertex_count(input logic [tsk_pkg::CFG_W-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.vcount = 32'(val);
    endtask

    // Random graph on n vertices: edges mostly go lower to higher rank in a shuffled order.
    task automatic random_graph(input int n, input int edges, input bit make_cycle);
        int perm[NV];
        int a, b, t;
        for (int i = 0; i < NV; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            b = $urandom_range(i);
            t = perm[i]; perm[i] = perm[b]; perm[b] = t;
        end
        for (int k = 0; k < edges; k++) begin
            if ($urandom_range(19) == 0) begin
                send_item(6'($urandom), 6'($urandom), 1'($urandom_range(1)), 1'b0);
            end else begin
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
                if (a > b) begin t = a; a = b; b = t; end
                if (make_cycle && k == edges - 1)
                    send_item(6'(perm[b]), 6'(perm[a]), 1'b1, 1'b0);
                else if (a != b)
                    send_item(6'(perm[a]), 6'(perm[b]), 1'b1, 1'b0);
            end
        end
        send_item(6'($urandom), 6'($urandom), 1'b0, 1'b1);
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int n, m;
        sent = 0;
        while (sent < n_items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 10);
            set_vertex_count(7'(n));
            if (n == 0) n = 1;
            m = $urandom_range(0, 2 * n);
            if (m > 16) m = 16;
            if ($urandom_range(9) == 0) begin
                // vertex 63, out of range for any setting below 64
                send_item(6'($urandom_range(63)), 6'd63, 1'b1, 1'b1);
                sent++;
            end else begin
                random_graph(n, m, ($urandom_range(3) == 0) && n > 1);
                sent += m + 1;
            end
        end
    endtask

    initial begin
        sb.vcount = 32'(tsk_pkg::VCOUNT_RESET);
        sb.clear_graph();
        sb.errors = 0;
        sb.checked = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default count, single bare end marker gives 64 vertices in order.
        send_item(6'd0, 6'd0, 1'b0, 1'b1);
        set_vertex_count(7'd1);
        send_item(6'd0, 6'd0, 1'b0, 1'b0);          // ignored item
        send_item(6'd0, 6'd0, 1'b0, 1'b1);
        set_vertex_count(7'd0);                     // acts as one vertex
        send_item(6'd0, 6'd0, 1'b1, 1'b1);          // self loop: cycle
        set_vertex_count(7'd4);
        send_item(6'd3, 6'd2, 1'b1, 1'b0);
        send_item(6'd3, 6'd1, 1'b1, 1'b0);
        send_item(6'd2, 6'd0, 1'b1, 1'b0);
        send_item(6'd1, 6'd0, 1'b1, 1'b1);          // edge on the end item
        send_item(6'd1, 6'd2, 1'b1, 1'b0);
        send_item(6'd2, 6'd1, 1'b1, 1'b1);          // two-vertex cycle
        send_item(6'd0, 6'd63, 1'b1, 1'b1);         // vertex beyond count: error
        set_vertex_count(7'd127);                   // acts as the maximum
        send_item(6'd63, 6'd0, 1'b1, 1'b0);
        send_item(6'd42, 6'd21, 1'b1, 1'b1);
        set_vertex_count(7'd64);
        send_item(6'd0, 6'd0, 1'b0, 1'b1);

        send_idle = 24; recv_idle = 88;
        random_phase(30);
        send_idle = 88; recv_idle = 24;
        random_phase(30);
        send_idle = 0; recv_idle = 0;
        random_phase(30);
        set_vertex_count(7'd64);
        drain();

        $display("Sorted %0d graphs, checked %0d results including cycles and errors.",
                 graphs, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("topological_sort_kahn_tb OK");
        else
            $display("topological_sort_kahn_tb NOT OK");
        $finish;
    end
endmodule
